@@ rtl/wvcr_pkg.sv @@
// Shared types and constants of the wide vector cyclic rotator.
`default_nettype none

package wvcr_pkg;

  localparam int WORD_BITS   = 64;
  localparam int INDEX_BITS  = 8;
  localparam int AMOUNT_BITS = 14;
  localparam int ACTION_BITS = 2;
  localparam int CODE_BITS   = 3;

  // Item kinds carried on the input tuser.
  localparam logic [ACTION_BITS-1:0] ACT_WRITE  = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_ROTATE = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_READ   = 2'd2;

  // Shift code k moves the vector by 2**k bits; the largest code moves a whole word.
  localparam logic [CODE_BITS-1:0] CODE_WORD = 3'd6;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                 move_word;
    logic                 move_bits;
    logic [CODE_BITS-1:0] shift_code;
  } ctl_t;

endpackage

`default_nettype wire

@@ rtl/wvcr_cell.sv @@
// One storage cell of the rotator ring: holds one word and moves it by word or by bits.
`default_nettype none

module wvcr_cell #(
  parameter int LIVE_BITS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire wvcr_pkg::ctl_t                 ctl,
  input  wire logic [wvcr_pkg::WORD_BITS-1:0] word_in,
  input  wire logic [wvcr_pkg::WORD_BITS-1:0] follow,
  output logic      [wvcr_pkg::WORD_BITS-1:0] word_o
);
  import wvcr_pkg::*;

  logic [WORD_BITS-1:0]           word_r;
  logic [WORD_BITS-1:0]           word_nxt;
  logic [LIVE_BITS+WORD_BITS-1:0] window;
  logic [LIVE_BITS+WORD_BITS-1:0] shifted;
  logic [CODE_BITS+3:0]           shift_amt;

  // The window is this cell's live bits with the next word of the cyclic vector on top.
  assign window    = {follow, word_r[LIVE_BITS-1:0]};
  assign shift_amt = (CODE_BITS+4)'(1) << ctl.shift_code;
  assign shifted   = window >> shift_amt;

  always_comb begin
    word_nxt = word_r;
    if (ctl.move_word) begin
      word_nxt = word_in;
    end else if (ctl.move_bits) begin
      word_nxt = WORD_BITS'(shifted[LIVE_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign word_o = word_r;

endmodule

`default_nettype wire

@@ rtl/wide_vector_cyclic_rotate.sv @@
// Top level of the wide vector cyclic rotator: a ring of word cells and its sequencer.
//
// The block stores a VECTOR_BITS-bit vector as 64-bit words, least significant word
// first, in a ring of cells. Input beats arrive on in_tvalid/in_tready with the kind on
// in_tuser (0 write word, 1 rotate right, 2 read word) and the operands on in_tdata.
// Only read beats produce an output beat on out_tvalid/out_tready.
// A write or a read in range turns the ring by one word per cycle for one full turn,
// replacing or capturing the addressed word as it passes cell zero; a read then loads
// the output register from its result state. A read beyond the last word returns zero
// through the result state; a write there is dropped.
// A rotate moves every cell by the same number of bits in each cycle: 64 bits while at
// least 64 remain, then the set bits of the remainder from the highest down, amounts at
// or above VECTOR_BITS simply wrapping further.
// One item is in work at a time; in_tready is high only while the sequencer is idle.
// The output register lets the next item start while a read result waits; a finished
// read waits in its own state until the output register is free.
// Synchronous reset clears every stored word to zero and empties the output register.
`default_nettype none

module wide_vector_cyclic_rotate #(
  parameter int VECTOR_BITS = 12323
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,   // word_index[7:0], word_data[71:8], rotate_amount[85:72]
  input  wire logic [1:0]  in_tuser,   // action[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata   // read_data[63:0]
);
  import wvcr_pkg::*;

  localparam int WORDS    = (VECTOR_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int TOP_BITS = VECTOR_BITS - WORD_BITS * (WORDS - 1);
  localparam int IDX_BITS = $clog2(WORDS);
  localparam int CMP_BITS = (IDX_BITS > INDEX_BITS) ? IDX_BITS + 1 : INDEX_BITS + 1;
  localparam logic [WORD_BITS-1:0] TOP_MASK =
    (TOP_BITS == WORD_BITS) ? {WORD_BITS{1'b1}} : ((WORD_BITS'(1) << TOP_BITS) - 1'b1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORD = 2'd1;
  localparam logic [1:0] ST_ROT  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0]             state_r,     state_nxt;
  logic [IDX_BITS-1:0]    step_r,      step_nxt;
  logic                   is_read_r,   is_read_nxt;
  logic [INDEX_BITS-1:0]  idx_r,       idx_nxt;
  logic [WORD_BITS-1:0]   data_r,      data_nxt;
  logic [AMOUNT_BITS-1:0] rem_r,       rem_nxt;
  logic [WORD_BITS-1:0]   hold_r,      hold_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0]   out_data_r,  out_data_nxt;

  logic [ACTION_BITS-1:0] in_action;
  logic [INDEX_BITS-1:0]  in_index;
  logic [WORD_BITS-1:0]   in_data;
  logic [AMOUNT_BITS-1:0] in_amount;
  logic                   in_fire;
  logic                   in_range;
  logic                   at_index;
  logic                   last_step;
  logic [CODE_BITS-1:0]   pick_code;
  logic [AMOUNT_BITS-1:0] pick_amount;
  ctl_t                   ctl;
  logic [WORD_BITS-1:0]   tail_in;
  logic [2*WORD_BITS-1:0] wrap_join;
  logic [WORD_BITS-1:0]   cell_word [WORDS];

  assign in_index  = in_tdata[7:0];
  assign in_data   = in_tdata[71:8];
  assign in_amount = in_tdata[85:72];
  assign in_action = in_tuser;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_range  = CMP_BITS'(in_index) < CMP_BITS'(WORDS);
  assign at_index  = CMP_BITS'(step_r) == CMP_BITS'(idx_r);
  assign last_step = step_r == IDX_BITS'(WORDS - 1);

  // Largest move for this cycle: a whole word, else the highest set bit of what is left.
  always_comb begin
    if (rem_r >= AMOUNT_BITS'(WORD_BITS)) begin
      pick_code = CODE_WORD;
    end else if (rem_r[5]) begin
      pick_code = 3'd5;
    end else if (rem_r[4]) begin
      pick_code = 3'd4;
    end else if (rem_r[3]) begin
      pick_code = 3'd3;
    end else if (rem_r[2]) begin
      pick_code = 3'd2;
    end else if (rem_r[1]) begin
      pick_code = 3'd1;
    end else begin
      pick_code = 3'd0;
    end
  end
  assign pick_amount = AMOUNT_BITS'(1) << pick_code;

  // During a word turn the word leaving cell zero re-enters at the tail, unless it is
  // the one being written.
  always_comb begin
    tail_in = cell_word[0];
    if (!is_read_r && at_index) begin
      tail_in = (CMP_BITS'(idx_r) == CMP_BITS'(WORDS - 1)) ? (data_r & TOP_MASK) : data_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    is_read_nxt    = is_read_r;
    idx_nxt        = idx_r;
    data_nxt       = data_r;
    rem_nxt        = rem_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ctl            = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt     = in_index;
          data_nxt    = in_data;
          rem_nxt     = in_amount;
          step_nxt    = '0;
          is_read_nxt = (in_action == ACT_READ);
          case (in_action)
            ACT_WRITE: begin
              if (in_range) begin
                state_nxt = ST_WORD;
              end
            end
            ACT_ROTATE: begin
              state_nxt = ST_ROT;
            end
            ACT_READ: begin
              if (in_range) begin
                state_nxt = ST_WORD;
              end else begin
                hold_nxt  = '0;
                state_nxt = ST_PUSH;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_WORD: begin
        ctl.move_word = 1'b1;
        if (is_read_r && at_index) begin
          hold_nxt = cell_word[0];
        end
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          step_nxt  = '0;
          state_nxt = is_read_r ? ST_PUSH : ST_IDLE;
        end
      end
      ST_ROT: begin
        if (rem_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          ctl.move_bits  = 1'b1;
          ctl.shift_code = pick_code;
          rem_nxt        = rem_r - pick_amount;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = hold_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_read_r  <= is_read_nxt;
    idx_r      <= idx_nxt;
    data_r     <= data_nxt;
    rem_r      <= rem_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The bits that follow the next-to-top word cyclically: the top word's live bits, then
  // word zero.
  assign wrap_join = {{WORD_BITS{1'b0}}, cell_word[WORDS-1] & TOP_MASK}
                   | ({{WORD_BITS{1'b0}}, cell_word[0]} << TOP_BITS);

  for (genvar i = 0; i < WORDS; i++) begin : g_cell
    logic [WORD_BITS-1:0] word_in;
    logic [WORD_BITS-1:0] follow;

    if (i < WORDS - 2) begin : g_body
      assign word_in = cell_word[i+1];
      assign follow  = cell_word[i+1];
    end else if (i == WORDS - 2) begin : g_below_top
      assign word_in = cell_word[i+1];
      assign follow  = wrap_join[WORD_BITS-1:0];
    end else begin : g_top
      assign word_in = tail_in;
      assign follow  = cell_word[0];
    end

    wvcr_cell #(
      .LIVE_BITS((i == WORDS - 1) ? TOP_BITS : WORD_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .word_in (word_in),
      .follow  (follow),
      .word_o  (cell_word[i])
    );
  end

  // Padding above the vector length never holds a one while the ring is at rest. During
  // a word turn the top cell carries full words passing through it.
  a_top_padding_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_WORD) |-> ((cell_word[WORDS-1] & ~TOP_MASK) == '0))
    else $error("padding bits of the top word are set");

  // The word-turn counter never runs past the last cell.
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_BITS'(step_r) < CMP_BITS'(WORDS))
    else $error("word turn counter out of range");

  // Each rotate cycle that moves bits leaves strictly less to do.
  a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROT && rem_r != '0) |=> (rem_r < $past(rem_r)))
    else $error("rotate amount did not shrink");

  // A word turn and a bit move are never requested together.
  a_one_move: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.move_word && ctl.move_bits))
    else $error("cells told to move by word and by bits at once");

  // A word turn always returns to the idle or the result state after exactly one lap.
  a_lap_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WORD && last_step) |=> (state_r == ST_IDLE || state_r == ST_PUSH))
    else $error("word turn did not end after one lap");

endmodule

`default_nettype wire
